// ===== hdl/bitmap_first_fit_block_alloc_top_macros.svh =====
`ifndef BITMAP_FIRST_FIT_BLOCK_ALLOC_TOP_MACROS_SVH
`define BITMAP_FIRST_FIT_BLOCK_ALLOC_TOP_MACROS_SVH

// check on clk, off during reset
`define BFFA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bffa check failed");

// same with a custom message
`define BFFA_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== hdl/bffa_pkg.sv =====
package bffa_pkg;

    localparam int DEF_MAX_BLOCKS    = 4096;
    localparam int DEF_MAP_WORD_BITS = 8;

    localparam int COUNT_W   = 13;
    localparam int BLK_W     = 12;
    localparam int IDX_W     = COUNT_W + 1;
    localparam int CFG_IDX_W = 2;
    localparam int LANE      = 8;
    localparam int END_LIMIT = (1 << COUNT_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLOCK  = CFG_IDX_W'(1);

    localparam logic [COUNT_W-1:0] RST_TOTAL = COUNT_W'(4096);
    localparam logic [BLK_W-1:0]   RST_FIRST = BLK_W'(1);

    function automatic logic [COUNT_W-1:0] scan_end(
        input logic [COUNT_W-1:0] total,
        input logic [COUNT_W-1:0] max_end
    );
        scan_end = (total > max_end) ? max_end : total;
    endfunction

    function automatic logic [COUNT_W-1:0] reload_free(
        input logic [COUNT_W-1:0] total,
        input logic [BLK_W-1:0]   first,
        input logic [COUNT_W-1:0] max_end
    );
        logic [COUNT_W-1:0] e;
        logic [COUNT_W-1:0] f;
        e = scan_end(total, max_end);
        f = {1'b0, first};
        reload_free = (e > f) ? (e - f) : '0;
    endfunction

endpackage

// ===== hdl/bitmap_first_fit_block_alloc_top.sv =====
// a request that passes the free-count check scans the map word by word from block 0 up to
// the word that ends the run (at most ceil(scan_end / 8) words), marks each word of the run
// and then loads the result register; a rejected request goes straight to the result state
// the block returns to idle as the result loads and takes the next request, even while it waits
// reset: asynchronous, active low; the map memory is then cleared one word per cycle,
// all MAP_DEPTH words (512 by default), before the first request is taken
`include "bitmap_first_fit_block_alloc_top_macros.svh"

module bitmap_first_fit_block_alloc_top #(
    parameter int MAX_BLOCKS    = bffa_pkg::DEF_MAX_BLOCKS,
    parameter int MAP_WORD_BITS = bffa_pkg::DEF_MAP_WORD_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bffa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bffa_pkg::COUNT_W-1:0]     cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bffa_pkg::COUNT_W-1:0]     count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             ok,
    output logic [bffa_pkg::BLK_W-1:0]       start_block,
    output logic [bffa_pkg::COUNT_W-1:0]     free_left
);
    import bffa_pkg::*;

    localparam int MAP_DEPTH = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int AW        = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int OW        = $clog2(MAP_WORD_BITS);
    localparam int OFF_W     = OW + 1;
    localparam int MAX_END_I = (MAX_BLOCKS > END_LIMIT) ? END_LIMIT : MAX_BLOCKS;
    localparam logic [COUNT_W-1:0] MAX_END = COUNT_W'(MAX_END_I);
    localparam logic [OFF_W-1:0]   WB      = OFF_W'(MAP_WORD_BITS);
    localparam logic [OFF_W-1:0]   LANE_O  = OFF_W'(LANE);

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_SCAN, S_MARK, S_RES} state_t;

    logic [MAP_WORD_BITS-1:0] mem [MAP_DEPTH];
    logic [MAP_WORD_BITS-1:0] rdata_reg;
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [BLK_W-1:0]   first_reg, first_next;
    logic [COUNT_W-1:0] free_reg, free_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [AW-1:0]      wd_reg, wd_next;
    logic [OW-1:0]      off_reg, off_next;
    logic [IDX_W-1:0]   blk_reg, blk_next;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic [IDX_W-1:0]   st_blk_reg, st_blk_next;
    logic [AW-1:0]      st_wd_reg, st_wd_next;
    logic [OW-1:0]      st_bit_reg, st_bit_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic               hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg, ok_next;
    logic [BLK_W-1:0]   start_reg, start_next;
    logic [COUNT_W-1:0] free_left_reg, free_left_next;

    // lane scan
    logic [COUNT_W-1:0] l_run;
    logic [IDX_W-1:0]   l_st_blk;
    logic [AW-1:0]      l_st_wd;
    logic [OW-1:0]      l_st_bit;
    logic               l_hit;
    logic [OFF_W-1:0]   l_bidx;
    logic [IDX_W-1:0]   l_b;
    logic [IDX_W-1:0]   end_ext;
    logic [IDX_W-1:0]   first_ext;

    always_comb
    begin
        l_run    = run_reg;
        l_st_blk = st_blk_reg;
        l_st_wd  = st_wd_reg;
        l_st_bit = st_bit_reg;
        l_hit    = 1'b0;
        l_bidx   = '0;
        l_b      = '0;
        end_ext   = {1'b0, scan_end(total_reg, MAX_END)};
        first_ext = {2'b00, first_reg};
        for (int j = 0; j < LANE; j++)
        begin
            l_bidx = {1'b0, off_reg} + OFF_W'(j);
            l_b    = blk_reg + IDX_W'(j);
            if (!l_hit && (l_bidx < WB) && (l_b < end_ext))
            begin
                if ((l_b < first_ext) || rdata_reg[l_bidx[OW-1:0]])
                begin
                    l_run = '0;
                end
                else
                begin
                    if (l_run == '0)
                    begin
                        l_st_blk = l_b;
                        l_st_wd  = wd_reg;
                        l_st_bit = l_bidx[OW-1:0];
                    end
                    l_run = l_run + COUNT_W'(1);
                    if (l_run == count_reg)
                    begin
                        l_hit = 1'b1;
                    end
                end
            end
        end
    end

    logic               last_lane;
    logic [IDX_W-1:0]   blk_adv;

    assign last_lane = (({1'b0, off_reg} + LANE_O) >= WB);
    assign blk_adv   = last_lane ? (blk_reg + IDX_W'(WB - {1'b0, off_reg}))
                                 : (blk_reg + IDX_W'(LANE));

    // run marking
    logic [MAP_WORD_BITS-1:0] mark_mask;
    logic [OFF_W-1:0]         avail;
    logic [COUNT_W-1:0]       take;
    logic [OFF_W-1:0]         m_diff;

    always_comb
    begin
        mark_mask = '0;
        m_diff    = '0;
        for (int b = 0; b < MAP_WORD_BITS; b++)
        begin
            m_diff = OFF_W'(b) - {1'b0, off_reg};
            if ((OFF_W'(b) >= {1'b0, off_reg}) && (COUNT_W'(m_diff) < rem_reg))
            begin
                mark_mask[b] = 1'b1;
            end
        end
        avail = WB - {1'b0, off_reg};
        take  = (COUNT_W'(avail) < rem_reg) ? COUNT_W'(avail) : rem_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        total_next     = total_reg;
        first_next     = first_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        wd_next        = wd_reg;
        off_next       = off_reg;
        blk_next       = blk_reg;
        run_next       = run_reg;
        st_blk_next    = st_blk_reg;
        st_wd_next     = st_wd_reg;
        st_bit_next    = st_bit_reg;
        rem_next       = rem_reg;
        hit_next       = hit_reg;
        ok_next        = ok_reg;
        start_next     = start_reg;
        free_left_next = free_left_reg;
        out_valid_next = out_valid_reg && out_stall;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        in_stall       = (state_reg != S_IDLE);

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TOTAL_BLOCKS:
                begin
                    total_next = cfg_wdata;
                    free_next  = reload_free(cfg_wdata, first_reg, MAX_END);
                end
                REG_FIRST_BLOCK:
                begin
                    first_next = cfg_wdata[BLK_W-1:0];
                    free_next  = reload_free(total_reg, cfg_wdata[BLK_W-1:0], MAX_END);
                end
                default:
                begin
                    total_next = total_reg;
                end
            endcase
        end

        case (state_reg)
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MAP_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    count_next = count;
                    wd_next    = '0;
                    off_next   = '0;
                    blk_next   = '0;
                    run_next   = '0;
                    hit_next   = 1'b0;
                    mem_raddr  = '0;
                    if ((count != '0) && (count <= free_reg))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RES;
                    end
                end
            end
            S_SCAN:
            begin
                if (l_hit)
                begin
                    hit_next    = 1'b1;
                    st_blk_next = l_st_blk;
                    wd_next     = l_st_wd;
                    off_next    = l_st_bit;
                    rem_next    = count_reg;
                    mem_raddr   = l_st_wd;
                    state_next  = S_MARK;
                end
                else if (blk_adv >= end_ext)
                begin
                    state_next = S_RES;
                end
                else
                begin
                    run_next    = l_run;
                    st_blk_next = l_st_blk;
                    st_wd_next  = l_st_wd;
                    st_bit_next = l_st_bit;
                    blk_next    = blk_adv;
                    if (last_lane)
                    begin
                        wd_next   = wd_reg + AW'(1);
                        off_next  = '0;
                        mem_raddr = wd_reg + AW'(1);
                    end
                    else
                    begin
                        off_next  = off_reg + OW'(LANE);
                        mem_raddr = wd_reg;
                    end
                end
            end
            S_MARK:
            begin
                mem_we    = 1'b1;
                mem_waddr = wd_reg;
                mem_wdata = rdata_reg | mark_mask;
                rem_next  = rem_reg - take;
                wd_next   = wd_reg + AW'(1);
                off_next  = '0;
                mem_raddr = wd_reg + AW'(1);
                if (rem_reg == take)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = hit_reg;
                    if (hit_reg)
                    begin
                        free_next      = free_reg - count_reg;
                        free_left_next = free_reg - count_reg;
                        start_next     = st_blk_reg[BLK_W-1:0];
                    end
                    else
                    begin
                        free_left_next = free_reg;
                        start_next     = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            total_reg     <= RST_TOTAL;
            first_reg     <= RST_FIRST;
            free_reg      <= reload_free(RST_TOTAL, RST_FIRST, MAX_END);
            count_reg     <= '0;
            wd_reg        <= '0;
            off_reg       <= '0;
            blk_reg       <= '0;
            run_reg       <= '0;
            st_blk_reg    <= '0;
            st_wd_reg     <= '0;
            st_bit_reg    <= '0;
            rem_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            start_reg     <= '0;
            free_left_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            total_reg     <= total_next;
            first_reg     <= first_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            wd_reg        <= wd_next;
            off_reg       <= off_next;
            blk_reg       <= blk_next;
            run_reg       <= run_next;
            st_blk_reg    <= st_blk_next;
            st_wd_reg     <= st_wd_next;
            st_bit_reg    <= st_bit_next;
            rem_reg       <= rem_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            start_reg     <= start_next;
            free_left_reg <= free_left_next;
        end
    end

    // map memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign start_block = start_reg;
    assign free_left   = free_left_reg;

    `BFFA_ASSERT(a_we_state, mem_we |-> (state_reg == S_CLR || state_reg == S_MARK))
    `BFFA_ASSERT(a_mark_rem, (state_reg == S_MARK) |-> (rem_reg != '0))
    `BFFA_ASSERT(a_run_short, (state_reg == S_SCAN) |-> (run_reg < count_reg))
    `BFFA_ASSERT_MSG(a_fail_zero, out_valid_reg && !ok_reg |-> start_reg == '0, "fail start set")

endmodule

// ===== tb/bffa_alloc_sb_pkg.sv =====
package bffa_alloc_sb_pkg;
    import bffa_pkg::*;

    typedef struct packed {
        logic               ok;
        logic [BLK_W-1:0]   start_block;
        logic [COUNT_W-1:0] free_left;
    } alloc_word_t;

    class alloc_scoreboard;
        bit                 blk_used[DEF_MAX_BLOCKS];
        logic [COUNT_W-1:0] free_cnt;
        logic [COUNT_W-1:0] vol_total;
        logic [BLK_W-1:0]   vol_first;
        alloc_word_t        answers_due[$];
        int unsigned        mismatches;
        int unsigned        requests;
        int unsigned        granted;
        int unsigned        refused;
        int unsigned        checked;

        function new();
            foreach (blk_used[b])
            begin
                blk_used[b] = 1'b0;
            end
            vol_total   = RST_TOTAL;
            vol_first   = RST_FIRST;
            mismatches  = 0;
            requests    = 0;
            granted     = 0;
            refused     = 0;
            checked     = 0;
            refill();
        endfunction

        function int unsigned span_end();
            int unsigned t;
            t = 32'(vol_total);
            return (t > DEF_MAX_BLOCKS) ? DEF_MAX_BLOCKS : t;
        endfunction

        // free count = clamped total - first, reset on a total or first write
        function void refill();
            int unsigned e;
            int unsigned f;
            e = span_end();
            f = 32'(vol_first);
            free_cnt = (e > f) ? COUNT_W'(e - f) : '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] data);
            if (idx == REG_TOTAL_BLOCKS)
            begin
                vol_total = data;
                refill();
            end
            else if (idx == REG_FIRST_BLOCK)
            begin
                vol_first = data[BLK_W-1:0];
                refill();
            end
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        function void note_request(logic [COUNT_W-1:0] n);
            int unsigned stop;
            int unsigned run;
            int unsigned base;
            int unsigned b;
            bit          hit;
            alloc_word_t want;
            stop = span_end();
            run  = 0;
            base = 0;
            hit  = 1'b0;
            requests++;
            if (n != 0 && n <= free_cnt)
            begin
                for (b = 32'(vol_first); b < stop && !hit; b++)
                begin
                    if (blk_used[b])
                    begin
                        run = 0;
                    end
                    else
                    begin
                        if (run == 0)
                            base = b;
                        run++;
                        hit = (run == n);
                    end
                end
            end
            if (hit)
            begin
                for (b = base; b < base + n; b++)
                begin
                    blk_used[b] = 1'b1;
                end
                free_cnt         = free_cnt - n;
                want.ok          = 1'b1;
                want.start_block = BLK_W'(base);
                granted++;
            end
            else
            begin
                want.ok          = 1'b0;
                want.start_block = '0;
                refused++;
            end
            want.free_left = free_cnt;
            answers_due.push_back(want);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic got_ok, logic [BLK_W-1:0] got_start,
                          logic [COUNT_W-1:0] got_free);
            alloc_word_t want;
            bit          bad;
            checked++;
            if (answers_due.size() == 0)
            begin
                report_mismatch($sformatf("word with no request: ok=%0b start=%0d free=%0d",
                                          got_ok, got_start, got_free));
                return;
            end
            want = answers_due.pop_front();
            bad  = 1'b0;
            if (got_ok !== want.ok)
                bad = 1'b1;
            if (got_start !== want.start_block)
                bad = 1'b1;
            if (got_free !== want.free_left)
                bad = 1'b1;
            if (bad)
                report_mismatch($sformatf("got ok=%0b start=%0d free=%0d, want %0b/%0d/%0d",
                                          got_ok, got_start, got_free,
                                          want.ok, want.start_block, want.free_left));
        endtask
    endclass

endpackage

// ===== tb/tb_bitmap_first_fit_block_alloc_top.sv =====
module tb_bitmap_first_fit_block_alloc_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;
    import bffa_alloc_sb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int RANDOM_ITEMS    = 700;
    localparam int TAIL_CYCLES     = 1100;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COUNT_W-1:0] cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic [COUNT_W-1:0] count;
    logic               out_valid;
    logic               out_stall;
    logic               ok;
    logic [BLK_W-1:0]   start_block;
    logic [COUNT_W-1:0] free_left;

    alloc_scoreboard sb;
    bit              no_idle;
    bit              hold_off;
    bit              pressure_go;
    int unsigned     phases;

    bitmap_first_fit_block_alloc_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .count       (count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .start_block (start_block),
        .free_left   (free_left)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        return no_idle ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return COUNT_W'($urandom_range(1, 6));
        if (r < 75)
            return COUNT_W'($urandom_range(1, 40));
        if (r < 83)
            return '0;
        if (r < 90)
            return COUNT_W'(sb.free_cnt + $urandom_range(0, 1));
        return COUNT_W'($urandom_range(0, 4096));
    endfunction

    task automatic send_request(input logic [COUNT_W-1:0] n);
        int gap;
        gap = pick_gap();
        cfg_wr_en <= 1'b0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        count    <= n;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_request(n);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic setup_random_volume();
        logic [COUNT_W-1:0] tot;
        logic [COUNT_W-1:0] fw;
        int unsigned        base;
        case ($urandom_range(0, 9))
            0:
            begin
                tot = COUNT_W'($urandom_range(4096, 8191));
                fw  = COUNT_W'($urandom_range(0, 8191));
            end
            1:
            begin
                fw  = COUNT_W'($urandom_range(0, 8191));
                tot = COUNT_W'($urandom_range(0, fw[BLK_W-1:0]));
            end
            default:
            begin
                base = $urandom_range(0, 3800);
                fw   = COUNT_W'(base);
                fw[COUNT_W-1] = 1'($urandom_range(0, 1));
                tot  = COUNT_W'(base + $urandom_range(1, 400));
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                      COUNT_W'($urandom_range(0, 8191)));
        if ($urandom_range(0, 1))
        begin
            write_reg(REG_TOTAL_BLOCKS, tot);
            write_reg(REG_FIRST_BLOCK, fw);
        end
        else
        begin
            write_reg(REG_FIRST_BLOCK, fw);
            write_reg(REG_TOTAL_BLOCKS, tot);
        end
    endtask

    // result side: random stall per word, plus the long hold-off
    initial
    begin : result_sink
        int hold;
        hold      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                sb.check_result(ok, start_block, free_left);
                hold = pick_gap();
            end
            @(negedge clk);
            out_stall <= hold_off || (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    initial
    begin : long_hold
        hold_off = 1'b0;
        wait (pressure_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin : watchdog
        #32ms;
        $display("simulation failed");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int phase_len;
        int k;
        sb          = new();
        no_idle     = 1'b0;
        pressure_go = 1'b0;
        phases      = 0;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        count       = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset volume: zero, oversize, small grants, count above free
        send_request(COUNT_W'(0));
        send_request(COUNT_W'(4096));
        send_request(COUNT_W'(1));
        send_request(COUNT_W'(3));
        send_request(COUNT_W'(4095));
        settle();

        // run restarts after a used block, then no run left
        write_reg(REG_TOTAL_BLOCKS, COUNT_W'(16));
        write_reg(REG_FIRST_BLOCK, COUNT_W'(0));
        send_request(COUNT_W'(8));
        send_request(COUNT_W'(4));
        send_request(COUNT_W'(3));
        send_request(COUNT_W'(1));
        settle();

        // top bit of first block dropped, last block of the map
        write_reg(REG_FIRST_BLOCK, COUNT_W'(13'h1fff));
        write_reg(REG_TOTAL_BLOCKS, COUNT_W'(4096));
        send_request(COUNT_W'(1));
        send_request(COUNT_W'(1));
        settle();

        // volume larger than the map
        write_reg(REG_TOTAL_BLOCKS, COUNT_W'(8191));
        write_reg(REG_FIRST_BLOCK, COUNT_W'(4000));
        send_request(COUNT_W'(50));
        send_request(COUNT_W'(96));
        settle();

        // first block past the end, empty volume
        write_reg(REG_TOTAL_BLOCKS, COUNT_W'(100));
        write_reg(REG_FIRST_BLOCK, COUNT_W'(200));
        send_request(COUNT_W'(1));
        settle();
        write_reg(REG_TOTAL_BLOCKS, COUNT_W'(0));
        send_request(COUNT_W'(1));
        settle();

        // unused indexes leave everything alone
        write_reg(REG_SPARE_LO, COUNT_W'(13'h1fff));
        write_reg(REG_SPARE_HI, COUNT_W'(5));
        write_reg(REG_TOTAL_BLOCKS, COUNT_W'(1));
        write_reg(REG_FIRST_BLOCK, COUNT_W'(0));
        send_request(COUNT_W'(1));
        send_request(COUNT_W'(4096));
        settle();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            setup_random_volume();
            no_idle = ($urandom_range(0, 4) == 0);
            if (phases == 1)
                pressure_go = 1'b1;
            phase_len = $urandom_range(20, 80);
            if (phase_len > RANDOM_ITEMS - sent)
                phase_len = RANDOM_ITEMS - sent;
            for (k = 0; k < phase_len; k++)
                send_request(pick_count());
            settle();
            sent += phase_len;
            phases++;
        end

        repeat (TAIL_CYCLES) @(negedge clk);
        $display("%0d requests over %0d random volume settings: %0d granted, %0d refused",
                 sb.requests, phases, sb.granted, sb.refused);
        $display("%0d words checked, including clamped, empty and spare-index setups",
                 sb.checked);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bffa_pkg.sv
hdl/bitmap_first_fit_block_alloc_top.sv
tb/bffa_alloc_sb_pkg.sv
tb/tb_bitmap_first_fit_block_alloc_top.sv
